// ===== hw/rtl/uvs_pkg.sv =====
// Shared types, constants and helpers for the UV sphere vertex generator.
package uvs_pkg;

    localparam int IDX_W  = 10;
    localparam int RAD_W  = 16;
    localparam int POS_W  = 17;
    localparam int TEX_W  = 17;
    localparam int VTX_W  = 20;
    localparam int CFG_W  = 16;
    localparam int CFG_IW = 2;

    typedef enum logic [CFG_IW-1:0] {
        REG_RADIUS = 2'd0,
        REG_STACKS = 2'd1,
        REG_SLICES = 2'd2
    } t_reg_idx;

    localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [IDX_W-1:0] STACKS_RST = 10'd16;
    localparam logic [IDX_W-1:0] SLICES_RST = 10'd32;

    // divider: 36 quotient bits, 4 per stage
    localparam int DIV_Q_W  = 36;
    localparam int DIV_ST   = 9;
    localparam int DIV_STEP = 4;

    // sine lanes: 0 sin(phi), 1 cos(phi), 2 sin(theta), 3 cos(theta)
    localparam int LANES    = 4;
    localparam int HORNER_N = 5;
    localparam int LANE_ST  = 2 + 3 * HORNER_N + 1;

    localparam logic [30:0] ONE30       = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [61:0] HALF30_62   = 62'h2000_0000;

    localparam logic [6:0] HORN_K [HORNER_N] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [31:0] HORN_RCP [HORNER_N] = '{
        32'((64'd1 << 34) / 64'd110),
        32'((64'd1 << 34) / 64'd72),
        32'((64'd1 << 34) / 64'd42),
        32'((64'd1 << 34) / 64'd20),
        32'((64'd1 << 34) / 64'd6)
    };

    typedef struct packed {
        logic        hi;   // angle in lower half turn: result negative
        logic [30:0] x;
        logic [31:0] x2;
        logic [30:0] h;
        logic [62:0] p;
        logic [32:0] t;
        logic [64:0] tm;
        logic [16:0] m;
        logic        ng;
    } t_lane;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             quad;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] c;
        logic [VTX_W-1:0] d;
    } t_side;

    typedef struct packed {
        logic [10:0]        rem;
        logic [DIV_Q_W-1:0] q;
    } t_div;

    // four restoring steps: compare, subtract, shift
    function automatic t_div div4(input t_div s, input logic [IDX_W-1:0] d);
        t_div        o;
        logic        b;
        logic [10:0] rs;
        o = s;
        for (int k = 0; k < DIV_STEP; k++) begin
            b   = (o.rem >= {1'b0, d});
            rs  = b ? (o.rem - {1'b0, d}) : o.rem;
            o.q = {o.q[DIV_Q_W-2:0], b};
            o.rem = {rs[9:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// UV sphere vertex generator: position, texture coordinates and quad corners per grid point.
//
//  channel  dir  handshake                  payload
//  s        in   i_s_tvalid / o_s_tready    i_s_tdata  {slice_index, stack_index}
//  m        out  o_m_tvalid / i_m_tready    o_m_tdata  pos, tex, quad_valid, corners
//  cfg      in   i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// One beat per cycle, while the output is not stalled, through 30 register stages; a beat
// taken in stage 0 is offered on the m side by stage 29. Stage 0 clamps and forms the
// corners, stages 1-9 run two restoring dividers at 4 quotient bits each, stages 10-27
// the four sine lanes (one Horner term every three stages), stage 28 the trig product,
// stage 29 the radius product and output register.
// Reset clears the valid bits and loads the register defaults.
// A stalled output holds every stage in place; the input is taken whenever the output
// register is empty or being drained.
module uv_sphere_vertex_generator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [23:0]               i_s_tdata,   // stack_index, slice_index, pad
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [167:0]              o_m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v,
                                                   // quad_valid, corner_a..d, pad
    input  logic                      i_cfg_wr_en,
    input  logic [uvs_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [uvs_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int NST = 30;

    logic [15:0] r_radius;
    logic [9:0]  r_stacks;
    logic [9:0]  r_slices;

    logic [NST-1:0] r_vld;
    logic           en;

    uvs_pkg::t_div  r_da [uvs_pkg::DIV_ST+1];
    uvs_pkg::t_div  r_db [uvs_pkg::DIV_ST+1];
    uvs_pkg::t_div  n_da [uvs_pkg::DIV_ST+1];
    uvs_pkg::t_div  n_db [uvs_pkg::DIV_ST+1];
    uvs_pkg::t_side r_sb [29];
    uvs_pkg::t_side n_sb [29];
    uvs_pkg::t_lane r_ln [uvs_pkg::LANE_ST][uvs_pkg::LANES];
    uvs_pkg::t_lane n_ln [uvs_pkg::LANE_ST][uvs_pkg::LANES];

    logic [16:0] r_pxm, r_pzm, r_cpm, n_pxm, n_pzm;
    logic        r_nx, r_ny, r_nz;
    logic [16:0] r_ox, r_oy, r_oz, n_ox, n_oy, n_oz;
    uvs_pkg::t_side r_osb;

    // combinational temporaries
    logic [9:0]  ns, nl, ii, jj, ic, jc;
    logic [10:0] stride;
    logic [19:0] va;
    logic [31:0] ang [uvs_pkg::LANES];
    logic [31:0] phi, theta;
    logic [30:0] rr;
    logic [61:0] prod;
    logic [62:0] psum;
    logic [30:0] qd;
    logic [32:0] qk, rm;
    logic [30:0] qq;
    logic [31:0] ss;
    logic [18:0] m0;
    logic [33:0] mx, my, mz;
    int          idx;

    assign en         = !r_vld[NST-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tdata  = {2'b00, r_osb.d, r_osb.c, r_osb.b, r_osb.a, r_osb.quad,
                         r_osb.tex_v, r_osb.tex_u, r_oz, r_oy, r_ox};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= uvs_pkg::RADIUS_RST;
            r_stacks <= uvs_pkg::STACKS_RST;
            r_slices <= uvs_pkg::SLICES_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                uvs_pkg::REG_RADIUS: r_radius <= i_cfg_data;
                uvs_pkg::REG_STACKS: r_stacks <= i_cfg_data[9:0];
                uvs_pkg::REG_SLICES: r_slices <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ns = (r_stacks == '0) ? 10'd1 : r_stacks;
        nl = (r_slices == '0) ? 10'd1 : r_slices;
        ii = i_s_tdata[9:0];
        jj = i_s_tdata[19:10];
        ic = (ii < ns) ? ii : ns;
        jc = (jj < nl) ? jj : nl;

        // stage 0: clamp, corners, divider seed
        stride = {1'b0, nl} + 11'd1;
        va     = {10'd0, ii} * {9'd0, stride} + {10'd0, jj};
        n_sb[0].tex_u = '0;
        n_sb[0].tex_v = '0;
        n_sb[0].quad  = (ii < ns) && (jj < nl);
        n_sb[0].a = n_sb[0].quad ? va : '0;
        n_sb[0].b = n_sb[0].quad ? va + {9'd0, stride} : '0;
        n_sb[0].c = n_sb[0].quad ? va + {9'd0, stride} + 20'd1 : '0;
        n_sb[0].d = n_sb[0].quad ? va + 20'd1 : '0;
        n_da[0].rem = {1'b0, ic};
        n_da[0].q   = '0;
        n_db[0].rem = {1'b0, jc};
        n_db[0].q   = '0;
        for (int s = 1; s <= uvs_pkg::DIV_ST; s++) begin
            n_da[s] = uvs_pkg::div4(r_da[s-1], ns);
            n_db[s] = uvs_pkg::div4(r_db[s-1], nl);
        end
        for (int s = 1; s < 29; s++) n_sb[s] = r_sb[s-1];

        // quotients are floor(index/count * 2^35)
        phi   = r_da[uvs_pkg::DIV_ST].q[35:4];
        theta = r_db[uvs_pkg::DIV_ST].q[34:3];
        n_sb[10].tex_u = r_db[uvs_pkg::DIV_ST].q[35:19];
        n_sb[10].tex_v = 17'h10000 - r_da[uvs_pkg::DIV_ST].q[35:19];
        ang[0] = phi;
        ang[1] = phi + 32'h4000_0000;
        ang[2] = theta;
        ang[3] = theta + 32'h4000_0000;

        rr = '0; prod = '0; psum = '0; qd = '0; qk = '0; rm = '0; qq = '0;
        ss = '0; m0 = '0; idx = 0;
        for (int l = 0; l < uvs_pkg::LANES; l++) begin
            // quarter-wave fold and turn to radians
            n_ln[0][l]    = r_ln[0][l];
            n_ln[0][l].hi = ang[l][31];
            rr   = ang[l][30] ? (uvs_pkg::ONE30 - {1'b0, ang[l][29:0]})
                              : {1'b0, ang[l][29:0]};
            prod = rr * uvs_pkg::HALF_PI_Q30;
            n_ln[0][l].x = 31'((prod + uvs_pkg::HALF30_62) >> 30);

            n_ln[1][l]   = r_ln[0][l];
            prod = r_ln[0][l].x * r_ln[0][l].x;
            n_ln[1][l].x2 = 32'((prod + uvs_pkg::HALF30_62) >> 30);
            n_ln[1][l].h  = uvs_pkg::ONE30;

            // Horner terms: h = 1 - round(trunc(x2*h/k))
            for (int n = 0; n < uvs_pkg::HORNER_N; n++) begin
                idx = 2 + 3 * n;
                n_ln[idx][l]   = r_ln[idx-1][l];
                n_ln[idx][l].p = {31'd0, r_ln[idx-1][l].x2} * {32'd0, r_ln[idx-1][l].h};

                n_ln[idx+1][l] = r_ln[idx][l];
                psum = r_ln[idx][l].p + (63'(uvs_pkg::HORN_K[n]) << 29);
                n_ln[idx+1][l].t  = psum[62:30];
                n_ln[idx+1][l].tm = {32'd0, psum[62:30]} * {33'd0, uvs_pkg::HORN_RCP[n]};

                n_ln[idx+2][l] = r_ln[idx+1][l];
                qd = 31'(r_ln[idx+1][l].tm >> 34);
                qk = {2'd0, qd} * {26'd0, uvs_pkg::HORN_K[n]};
                rm = r_ln[idx+1][l].t - qk;
                qq = qd + ((rm >= 33'(uvs_pkg::HORN_K[n])) ? 31'd1 : 31'd0);
                n_ln[idx+2][l].h = uvs_pkg::ONE30 - qq;
            end

            n_ln[uvs_pkg::LANE_ST-1][l] = r_ln[uvs_pkg::LANE_ST-2][l];
            prod = r_ln[uvs_pkg::LANE_ST-2][l].x * r_ln[uvs_pkg::LANE_ST-2][l].h;
            ss   = 32'((prod + uvs_pkg::HALF30_62) >> 30);
            m0   = 19'(({1'b0, ss} + 33'h2000) >> 14);
            n_ln[uvs_pkg::LANE_ST-1][l].m  = (m0 > 19'h10000) ? 17'h10000 : m0[16:0];
            n_ln[uvs_pkg::LANE_ST-1][l].ng = r_ln[uvs_pkg::LANE_ST-2][l].hi &&
                                             (n_ln[uvs_pkg::LANE_ST-1][l].m != '0);
        end

        // stage 28: sin(phi) times the azimuth terms
        mx = {17'd0, r_ln[uvs_pkg::LANE_ST-1][0].m} * {17'd0, r_ln[uvs_pkg::LANE_ST-1][3].m}
             + 34'd32768;
        mz = {17'd0, r_ln[uvs_pkg::LANE_ST-1][0].m} * {17'd0, r_ln[uvs_pkg::LANE_ST-1][2].m}
             + 34'd32768;
        n_pxm = 17'(mx >> 16);
        n_pzm = 17'(mz >> 16);

        // stage 29: radius scale and sign
        mx = {18'd0, r_radius} * {17'd0, r_pxm} + 34'd32768;
        my = {18'd0, r_radius} * {17'd0, r_cpm} + 34'd32768;
        mz = {18'd0, r_radius} * {17'd0, r_pzm} + 34'd32768;
        n_ox = 17'(mx >> 16);
        n_oy = 17'(my >> 16);
        n_oz = 17'(mz >> 16);
        if (r_nx) n_ox = 17'(0) - n_ox;
        if (r_ny) n_oy = 17'(0) - n_oy;
        if (r_nz) n_oz = 17'(0) - n_oz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s <= uvs_pkg::DIV_ST; s++) begin
                r_da[s] <= n_da[s];
                r_db[s] <= n_db[s];
            end
            for (int s = 0; s < 29; s++) r_sb[s] <= n_sb[s];
            for (int s = 0; s < uvs_pkg::LANE_ST; s++) begin
                for (int l = 0; l < uvs_pkg::LANES; l++) r_ln[s][l] <= n_ln[s][l];
            end
            r_pxm <= n_pxm;
            r_pzm <= n_pzm;
            r_cpm <= r_ln[uvs_pkg::LANE_ST-1][1].m;
            r_nx  <= r_ln[uvs_pkg::LANE_ST-1][0].ng ^ r_ln[uvs_pkg::LANE_ST-1][3].ng;
            r_ny  <= r_ln[uvs_pkg::LANE_ST-1][1].ng;
            r_nz  <= r_ln[uvs_pkg::LANE_ST-1][0].ng ^ r_ln[uvs_pkg::LANE_ST-1][2].ng;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r_oz  <= n_oz;
            r_osb <= r_sb[28];
        end
    end

endmodule
